// File: src/cso_pkg.sv
// Shared codes and control types for the capsule overlap tester.
package cso_pkg;

  // Shape test selected by the command field
  localparam logic [1:0] CMD_CAPSULE = 2'd0;
  localparam logic [1:0] CMD_SPHERE  = 2'd1;
  localparam logic [1:0] CMD_BOX     = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_CENTER_X    = 3'd0;
  localparam logic [2:0] REG_CENTER_Y    = 3'd1;
  localparam logic [2:0] REG_CENTER_Z    = 3'd2;
  localparam logic [2:0] REG_HALF_HEIGHT = 3'd3;
  localparam logic [2:0] REG_RADIUS      = 3'd4;

  // Reset values of the capsule shape (Q16.16: 50.0 and 25.0)
  localparam int RESET_HALF_HEIGHT = 3276800;
  localparam int RESET_RADIUS      = 1638400;

  // At or below this half height the capsule counts as a sphere at its center
  localparam int SHORT_HALF_HEIGHT = 32;

  // Per-stage control carried alongside the pipeline payload
  typedef struct packed {
    logic valid;
    logic live;
  } stage_ctl_t;

endpackage

// File: src/cso_geom.sv
// Geometry front end: input register, clamps and per-axis distance magnitudes.
module cso_geom #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  logic [1:0]                   command,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic signed [COORD_BITS-1:0] box_max_x,
  input  logic signed [COORD_BITS-1:0] box_max_y,
  input  logic signed [COORD_BITS-1:0] box_max_z,
  input  logic [COORD_BITS-2:0]        other_radius,
  input  logic [COORD_BITS-2:0]        other_half_height,
  input  logic signed [COORD_BITS-1:0] center_x,
  input  logic signed [COORD_BITS-1:0] center_y,
  input  logic signed [COORD_BITS-1:0] center_z,
  input  logic [COORD_BITS-2:0]        half_height,
  input  logic [COORD_BITS-2:0]        radius,
  output cso_pkg::stage_ctl_t          ctl,
  output logic [COORD_BITS:0]          mag_x,
  output logic [COORD_BITS:0]          mag_y,
  output logic [COORD_BITS:0]          mag_z,
  output logic [COORD_BITS-1:0]        reach
);
  import cso_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int W1 = COORD_BITS + 1;
  localparam int W2 = COORD_BITS + 2;

  // Clamp v into [lo, hi]; below lo wins over above hi
  function automatic logic signed [W-1:0] clamp_w(
    input logic signed [W-1:0] v,
    input logic signed [W-1:0] lo,
    input logic signed [W-1:0] hi
  );
    logic signed [W-1:0] r;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  // Absolute value; the callers' operands always fit W+1 bits of magnitude
  function automatic logic [W:0] mag_of(input logic signed [W2-1:0] v);
    logic [W2-1:0] a;
    a = v[W2-1] ? W2'(-v) : W2'(v);
    return a[W:0];
  endfunction

  // Input register
  logic                in_valid;
  logic [1:0]          in_cmd;
  logic signed [W-1:0] in_px, in_py, in_pz, in_bx, in_by, in_bz;
  logic [W-2:0]        in_orad, in_ohh;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= accept;
    end
    if (accept) begin
      in_cmd  <= command;
      in_px   <= point_x;
      in_py   <= point_y;
      in_pz   <= point_z;
      in_bx   <= box_max_x;
      in_by   <= box_max_y;
      in_bz   <= box_max_z;
      in_orad <= other_radius;
      in_ohh  <= other_half_height;
    end
  end

  // First stage: end-sphere centers, box clamp, lateral offsets
  logic signed [W1-1:0] hh_s, ohh_s, cz_s, pz_s;
  logic signed [W1-1:0] mt_next, mb_next, ot_next, ob_next;
  logic signed [W-1:0]  qx, qy, qz, xo, yo, zsrc_next;
  logic signed [W1-1:0] ex_next, ey_next;
  logic [W-1:0]         reach_next;
  logic                 live_next, box_cmd;

  always_comb begin
    hh_s    = W1'($signed({1'b0, half_height}));
    ohh_s   = W1'($signed({1'b0, in_ohh}));
    cz_s    = W1'(center_z);
    pz_s    = W1'(in_pz);
    mt_next = cz_s + hh_s;
    mb_next = cz_s - hh_s;
    ot_next = pz_s + ohh_s;
    ob_next = pz_s - ohh_s;

    qx = clamp_w(center_x, in_px, in_bx);
    qy = clamp_w(center_y, in_py, in_by);
    qz = clamp_w(center_z, in_pz, in_bz);

    box_cmd   = (in_cmd == CMD_BOX);
    xo        = box_cmd ? qx : in_px;
    yo        = box_cmd ? qy : in_py;
    zsrc_next = box_cmd ? qz : in_pz;
    // sign of the offset does not matter, only its magnitude
    ex_next   = W1'(center_x) - W1'(xo);
    ey_next   = W1'(center_y) - W1'(yo);

    reach_next = box_cmd ? W'(radius) : W'(radius) + W'(in_orad);

    case (in_cmd)
      CMD_CAPSULE, CMD_SPHERE, CMD_BOX: live_next = 1'b1;
      default:                          live_next = 1'b0;
    endcase
  end

  logic                 g1_valid, g1_live, g1_cap, g1_short;
  logic signed [W1-1:0] g1_mt, g1_mb, g1_ot, g1_ob, g1_ex, g1_ey;
  logic signed [W-1:0]  g1_zsrc;
  logic [W-1:0]         g1_reach;

  always_ff @(posedge clk) begin
    if (rst) begin
      g1_valid <= 1'b0;
    end else begin
      g1_valid <= in_valid;
    end
    g1_live  <= live_next;
    g1_cap   <= (in_cmd == CMD_CAPSULE);
    g1_short <= (half_height <= (W-1)'(SHORT_HALF_HEIGHT));
    g1_mt    <= mt_next;
    g1_mb    <= mb_next;
    g1_ot    <= ot_next;
    g1_ob    <= ob_next;
    g1_ex    <= ex_next;
    g1_ey    <= ey_next;
    g1_zsrc  <= zsrc_next;
    g1_reach <= reach_next;
  end

  // Second stage: closest axis point, Z gap, end-pair minimum
  logic signed [W1-1:0] zs1, ap;
  logic [W:0]           m0, m1, m2, m3, m01, m23, mz_min, az_next;

  always_comb begin
    zs1 = W1'(g1_zsrc);
    if (g1_short) ap = W1'(center_z);
    else if (zs1 < g1_mb) ap = g1_mb;
    else if (zs1 > g1_mt) ap = g1_mt;
    else ap = zs1;

    m0     = mag_of(W2'(g1_mt) - W2'(g1_ot));
    m1     = mag_of(W2'(g1_mt) - W2'(g1_ob));
    m2     = mag_of(W2'(g1_mb) - W2'(g1_ot));
    m3     = mag_of(W2'(g1_mb) - W2'(g1_ob));
    m01    = (m1 < m0) ? m1 : m0;
    m23    = (m3 < m2) ? m3 : m2;
    mz_min = (m23 < m01) ? m23 : m01;

    az_next = g1_cap ? mz_min : mag_of(W2'(zs1) - W2'(ap));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.valid <= 1'b0;
    end else begin
      ctl.valid <= g1_valid;
    end
    ctl.live <= g1_live;
    mag_x    <= mag_of(W2'(g1_ex));
    mag_y    <= mag_of(W2'(g1_ey));
    mag_z    <= az_next;
    reach    <= g1_reach;
  end

endmodule

// File: src/cso_sqsum.sv
// Squared-distance back end: split squares, sum and strict compare with reach^2.
module cso_sqsum #(
  parameter int COORD_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cso_pkg::stage_ctl_t   ctl_in,
  input  logic [COORD_BITS:0]   mag_x,
  input  logic [COORD_BITS:0]   mag_y,
  input  logic [COORD_BITS:0]   mag_z,
  input  logic [COORD_BITS-1:0] reach,
  output logic                  done,
  output logic                  hit
);
  import cso_pkg::*;

  localparam int M = COORD_BITS + 1;      // operand width
  localparam int L = (M + 1) / 2;         // low half
  localparam int H = M - L;               // high half
  localparam int Q = 2 * M;               // square width
  localparam int S = 2 * M + 2;           // sum width
  localparam int LANES = 4;               // x, y, z, reach

  logic [M-1:0] opnd [LANES];

  assign opnd[0] = mag_x;
  assign opnd[1] = mag_y;
  assign opnd[2] = mag_z;
  assign opnd[3] = M'(reach);

  // Partial products: one lane per operand
  stage_ctl_t     ctl_p, ctl_q;
  logic [2*H-1:0] pp_hh [LANES];
  logic [H+L-1:0] pp_hl [LANES];
  logic [2*L-1:0] pp_ll [LANES];
  logic [Q-1:0]   sq    [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic [H-1:0] a_hi;
    logic [L-1:0] a_lo;
    assign a_hi = opnd[i][M-1:L];
    assign a_lo = opnd[i][L-1:0];

    always_ff @(posedge clk) begin
      pp_hh[i] <= (2*H)'(a_hi) * (2*H)'(a_hi);
      pp_hl[i] <= (H+L)'(a_hi) * (H+L)'(a_lo);
      pp_ll[i] <= (2*L)'(a_lo) * (2*L)'(a_lo);
    end

    // Reassemble the square from its partial products
    always_ff @(posedge clk) begin
      sq[i] <= (Q'(pp_hh[i]) << (2*L)) + (Q'(pp_hl[i]) << (L+1)) + Q'(pp_ll[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_p.valid <= 1'b0;
      ctl_q.valid <= 1'b0;
    end else begin
      ctl_p.valid <= ctl_in.valid;
      ctl_q.valid <= ctl_p.valid;
    end
    ctl_p.live <= ctl_in.live;
    ctl_q.live <= ctl_p.live;
  end

  // Sum of squares against reach squared
  logic [S-1:0] dist_sq;
  logic         hit_next;

  always_comb begin
    dist_sq  = S'(sq[0]) + S'(sq[1]) + S'(sq[2]);
    hit_next = ctl_q.valid && ctl_q.live && (dist_sq < S'(sq[3]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      hit  <= 1'b0;
    end else begin
      done <= ctl_q.valid;
      hit  <= hit_next;
    end
  end

endmodule

// File: src/capsule_shape_overlap_test_top.sv
// done and hit are registered outputs, fed through the input, geometry, partial-product and square registers.
// Throughput: one shape per cycle; busy is always low, the six-stage pipeline never stalls.
// The width of the split squaring multipliers (about COORD_BITS/2) sets the stage depth.
// Each beat gives exactly one done strobe; the receiver cannot hold results off.
// Reset (rst, synchronous) empties the pipeline and restores capsule center 0,
// half height 50.0 and radius 25.0.
module capsule_shape_overlap_test_top #(
  parameter int COORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   command,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic signed [COORD_BITS-1:0] point_z,
  input  logic signed [COORD_BITS-1:0] box_max_x,
  input  logic signed [COORD_BITS-1:0] box_max_y,
  input  logic signed [COORD_BITS-1:0] box_max_z,
  input  logic [COORD_BITS-2:0]        other_radius,
  input  logic [COORD_BITS-2:0]        other_half_height,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [COORD_BITS-1:0]        cfg_data,
  output logic                         done,
  output logic                         hit
);
  import cso_pkg::*;

  localparam int W = COORD_BITS;

  // Capsule configuration registers
  logic signed [W-1:0] center_x, center_y, center_z;
  logic [W-2:0]        half_height, radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      center_z    <= '0;
      half_height <= (W-1)'(RESET_HALF_HEIGHT);
      radius      <= (W-1)'(RESET_RADIUS);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X:    center_x    <= $signed(cfg_data);
        REG_CENTER_Y:    center_y    <= $signed(cfg_data);
        REG_CENTER_Z:    center_z    <= $signed(cfg_data);
        REG_HALF_HEIGHT: half_height <= cfg_data[W-2:0];
        REG_RADIUS:      radius      <= cfg_data[W-2:0];
        default: ;
      endcase
    end
  end

  // Never stalls
  logic accept;
  assign busy   = 1'b0;
  assign accept = start && !busy;

  stage_ctl_t   geo_ctl;
  logic [W:0]   mag_x, mag_y, mag_z;
  logic [W-1:0] reach;

  cso_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .clk              (clk),
    .rst              (rst),
    .accept           (accept),
    .command          (command),
    .point_x          (point_x),
    .point_y          (point_y),
    .point_z          (point_z),
    .box_max_x        (box_max_x),
    .box_max_y        (box_max_y),
    .box_max_z        (box_max_z),
    .other_radius     (other_radius),
    .other_half_height(other_half_height),
    .center_x         (center_x),
    .center_y         (center_y),
    .center_z         (center_z),
    .half_height      (half_height),
    .radius           (radius),
    .ctl              (geo_ctl),
    .mag_x            (mag_x),
    .mag_y            (mag_y),
    .mag_z            (mag_z),
    .reach            (reach)
  );

  cso_sqsum #(.COORD_BITS(COORD_BITS)) u_sqsum (
    .clk   (clk),
    .rst   (rst),
    .ctl_in(geo_ctl),
    .mag_x (mag_x),
    .mag_y (mag_y),
    .mag_z (mag_z),
    .reach (reach),
    .done  (done),
    .hit   (hit)
  );

  // Every accepted beat comes out exactly once, at fixed latency
  a_accept_to_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##6 done)
    else $error("accepted beat produced no result");

  a_done_from_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, 6))
    else $error("result without an accepted beat");

  a_hit_needs_done: assert property (@(posedge clk)
    hit |-> done)
    else $error("hit outside a result cycle");

  a_unused_cmd_miss: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_NONE) |-> ##6 !hit)
    else $error("unused command reported a hit");

endmodule

// File: tb/overlap_check_pkg.sv
// Shape beat type and hit scoreboard for the capsule overlap tester bench.
package overlap_check_pkg;
  import cso_pkg::*;

  localparam int COORD_W = 32;

  // Index with no register behind it; writes to it must change nothing
  localparam logic [2:0] REG_SPARE = 3'd7;

  // One shape beat, in port order
  typedef struct packed {
    logic [1:0]                command;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic signed [COORD_W-1:0] box_max_x;
    logic signed [COORD_W-1:0] box_max_y;
    logic signed [COORD_W-1:0] box_max_z;
    logic [COORD_W-2:0]        other_radius;
    logic [COORD_W-2:0]        other_half_height;
  } shape_t;

  // Holds the capsule registers, predicts hit per shape and checks results in order
  class hit_scoreboard;
    longint cen_x, cen_y, cen_z;
    longint half_h, rad;
    bit     expected_hits[$];
    int     mismatches;
    int     results_seen;

    function new();
      cen_x = 0;
      cen_y = 0;
      cen_z = 0;
      half_h = RESET_HALF_HEIGHT;
      rad = RESET_RADIUS;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [COORD_W-1:0] data);
      case (idx)
        REG_CENTER_X:    cen_x = $signed(data);
        REG_CENTER_Y:    cen_y = $signed(data);
        REG_CENTER_Z:    cen_z = $signed(data);
        REG_HALF_HEIGHT: half_h = data[COORD_W-2:0];
        REG_RADIUS:      rad = data[COORD_W-2:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] mag(longint d);
      return (d < 0) ? 64'(-d) : 64'(d);
    endfunction

    function logic [127:0] sq(logic [63:0] m);
      logic [127:0] w;
      w = {64'd0, m};
      return w * w;
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // Closest point on the capsule axis; a very short capsule is just its center
    function longint axis_point(longint z);
      if (half_h <= SHORT_HALF_HEIGHT) return cen_z;
      return clamp(z, cen_z - half_h, cen_z + half_h);
    endfunction

    // Exact squared distance test, strict less-than
    function bit near_enough(longint dx, longint dy, logic [63:0] adz, logic [63:0] reach);
      return (sq(mag(dx)) + sq(mag(dy)) + sq(adz)) < sq(reach);
    endfunction

    function bit predict_hit(shape_t s);
      longint px, py, pz, bx, by, bz, orad, ohh;
      longint top_a, bot_a, top_b, bot_b, qx, qy, qz;
      logic [63:0] best, d;
      px = s.point_x;
      py = s.point_y;
      pz = s.point_z;
      bx = s.box_max_x;
      by = s.box_max_y;
      bz = s.box_max_z;
      orad = s.other_radius;
      ohh = s.other_half_height;
      case (s.command)
        CMD_CAPSULE: begin
          // nearest pair of end-sphere centers
          top_a = cen_z + half_h;
          bot_a = cen_z - half_h;
          top_b = pz + ohh;
          bot_b = pz - ohh;
          best = mag(top_a - top_b);
          d = mag(top_a - bot_b);
          if (d < best) best = d;
          d = mag(bot_a - top_b);
          if (d < best) best = d;
          d = mag(bot_a - bot_b);
          if (d < best) best = d;
          return near_enough(cen_x - px, cen_y - py, best, 64'(rad + orad));
        end
        CMD_SPHERE:
          return near_enough(px - cen_x, py - cen_y, mag(pz - axis_point(pz)),
                             64'(rad + orad));
        CMD_BOX: begin
          // box clamp also covers inverted bounds: minimum tested first
          qx = clamp(cen_x, px, bx);
          qy = clamp(cen_y, py, by);
          qz = clamp(cen_z, pz, bz);
          return near_enough(qx - cen_x, qy - cen_y, mag(qz - axis_point(qz)), 64'(rad));
        end
        default: return 1'b0;
      endcase
    endfunction

    function void note_shape(shape_t s);
      expected_hits.push_back(predict_hit(s));
    endfunction

    function void check_hit(logic got);
      bit want;
      results_seen++;
      if (expected_hits.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: unexpected done beat, hit=%b", results_seen, got);
        return;
      end
      want = expected_hits.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d: hit expected %0d, got %b", results_seen, want, got);
      end
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction
  endclass

endpackage

// File: tb/tb_top.sv
// Top-level bench for the capsule overlap tester: stimulus, drivers and result checking.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cso_pkg::*;
  import overlap_check_pkg::*;

  localparam int     Q_ONE        = 65536;
  localparam int     DRAIN_CYCLES = 12;
  localparam longint CYCLE_LIMIT  = 400000;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [1:0]                command = CMD_CAPSULE;
  logic signed [COORD_W-1:0] point_x = '0;
  logic signed [COORD_W-1:0] point_y = '0;
  logic signed [COORD_W-1:0] point_z = '0;
  logic signed [COORD_W-1:0] box_max_x = '0;
  logic signed [COORD_W-1:0] box_max_y = '0;
  logic signed [COORD_W-1:0] box_max_z = '0;
  logic [COORD_W-2:0]        other_radius = '0;
  logic [COORD_W-2:0]        other_half_height = '0;
  logic                      cfg_we = 1'b0;
  logic [2:0]                cfg_index = REG_CENTER_X;
  logic [COORD_W-1:0]        cfg_data = '0;
  logic                      done;
  logic                      hit;

  shape_t        port_shape;
  hit_scoreboard sb;
  longint        cycles = 0;
  shape_t        directed[$];

  assign port_shape = {command, point_x, point_y, point_z, box_max_x, box_max_y,
                       box_max_z, other_radius, other_half_height};

  capsule_shape_overlap_test_top uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .point_x(point_x),
    .point_y(point_y),
    .point_z(point_z),
    .box_max_x(box_max_x),
    .box_max_y(box_max_y),
    .box_max_z(box_max_z),
    .other_radius(other_radius),
    .other_half_height(other_half_height),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .done(done),
    .hit(hit)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // Monitor: register writes, accepted shapes, result beats
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (start && !busy) sb.note_shape(port_shape);
      if (done) sb.check_hit(hit);
    end
  end

  function automatic shape_t make_shape(logic [1:0] cmd, logic [31:0] px, logic [31:0] py,
                                        logic [31:0] pz, logic [31:0] bx, logic [31:0] by,
                                        logic [31:0] bz, logic [31:0] orad, logic [31:0] ohh);
    shape_t s;
    s.command = cmd;
    s.point_x = px;
    s.point_y = py;
    s.point_z = pz;
    s.box_max_x = bx;
    s.box_max_y = by;
    s.box_max_z = bz;
    s.other_radius = orad[COORD_W-2:0];
    s.other_half_height = ohh[COORD_W-2:0];
    return s;
  endfunction

  // Coordinate scattered around c; wraps at the extremes, which is still legal input
  function automatic logic [31:0] near_coord(longint c, longint base);
    longint off;
    off = longint'($urandom_range(0, 32'(4 * base))) - 2 * base;
    return 32'(c + off);
  endfunction

  // Box bounds around c; sometimes inverted
  function automatic void box_axis(longint c, longint base, output logic [31:0] lo,
                                   output logic [31:0] hi);
    longint size;
    lo = near_coord(c, base);
    size = $urandom_range(0, 32'(2 * base));
    if ($urandom_range(0, 7) == 0) hi = 32'($signed(lo) - size);
    else hi = 32'($signed(lo) + size);
  endfunction

  function automatic shape_t random_shape();
    shape_t s;
    longint base;
    int r;
    if ($urandom_range(0, 9) == 0) begin
      // anything goes
      s.command = 2'($urandom);
      s.point_x = $urandom;
      s.point_y = $urandom;
      s.point_z = $urandom;
      s.box_max_x = $urandom;
      s.box_max_y = $urandom;
      s.box_max_z = $urandom;
      s.other_radius = 31'($urandom);
      s.other_half_height = 31'($urandom);
      return s;
    end
    // scale placement to the capsule so hits and misses both occur
    base = sb.rad + sb.half_h;
    if (base < 64) base = 64;
    if (base > (64'sd1 << 29)) base = 64'sd1 << 29;
    r = $urandom_range(0, 19);
    if (r == 0) s.command = CMD_NONE;
    else if (r < 8) s.command = CMD_CAPSULE;
    else if (r < 14) s.command = CMD_SPHERE;
    else s.command = CMD_BOX;
    if (s.command == CMD_BOX) begin
      box_axis(sb.cen_x, base, s.point_x, s.box_max_x);
      box_axis(sb.cen_y, base, s.point_y, s.box_max_y);
      box_axis(sb.cen_z, base, s.point_z, s.box_max_z);
    end else begin
      s.point_x = near_coord(sb.cen_x, base);
      s.point_y = near_coord(sb.cen_y, base);
      s.point_z = near_coord(sb.cen_z, base);
      s.box_max_x = $urandom;
      s.box_max_y = $urandom;
      s.box_max_z = $urandom;
    end
    s.other_radius = 31'($urandom_range(0, 32'(base)));
    s.other_half_height = 31'($urandom_range(0, 32'(base)));
    return s;
  endfunction

  // Length register value: tiny, moderate or anything including bit 31
  function automatic logic [31:0] pick_length();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 64);
      3: return $urandom;
      default: return $urandom_range(0, 100 * Q_ONE);
    endcase
  endfunction

  task automatic send_shape(input shape_t s);
    @(negedge clk);
    start <= 1'b1;
    command <= s.command;
    point_x <= s.point_x;
    point_y <= s.point_y;
    point_z <= s.point_z;
    box_max_x <= s.box_max_x;
    box_max_y <= s.box_max_y;
    box_max_z <= s.box_max_z;
    other_radius <= s.other_radius;
    other_half_height <= s.other_half_height;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_sender(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Bursts of back-to-back beats, most of them followed by a random gap
  task automatic send_random(input int count);
    int left, burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) send_shape(random_shape());
      left -= burst;
      if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
    end
  endtask

  // Hold off until every result is back, then let the pipeline settle
  task automatic drain_results();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic program_capsule(input logic [31:0] cx, input logic [31:0] cy,
                                 input logic [31:0] cz, input logic [31:0] hh,
                                 input logic [31:0] rad);
    write_reg(REG_SPARE, $urandom);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_HALF_HEIGHT, hh);
    write_reg(REG_RADIUS, rad);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] cx, cy, cz, hh, rad;
    sb = new();

    // Directed shapes against the reset capsule: center 0, half height 50, radius 25
    directed.push_back(make_shape(CMD_SPHERE, 50 * Q_ONE, 0, 0, 0, 0, 0, 25 * Q_ONE, 0));
    directed.push_back(make_shape(CMD_SPHERE, 50 * Q_ONE - 1, 0, 0, 0, 0, 0, 25 * Q_ONE, 0));
    directed.push_back(make_shape(CMD_SPHERE, 0, 0, 100 * Q_ONE, 0, 0, 0, 25 * Q_ONE, 0));
    directed.push_back(make_shape(CMD_SPHERE, 0, 0, -100 * Q_ONE + 1, 0, 0, 0, 25 * Q_ONE, 0));
    directed.push_back(make_shape(CMD_CAPSULE, 60 * Q_ONE, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(make_shape(CMD_CAPSULE, 0, 0, 150 * Q_ONE, 0, 0, 0,
                                  25 * Q_ONE, 50 * Q_ONE));
    directed.push_back(make_shape(CMD_CAPSULE, 0, 0, 150 * Q_ONE - 1, 0, 0, 0,
                                  25 * Q_ONE, 50 * Q_ONE));
    // box around the center, beside it, inverted, and off the end of the axis
    directed.push_back(make_shape(CMD_BOX, -Q_ONE, -Q_ONE, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 0));
    directed.push_back(make_shape(CMD_BOX, 25 * Q_ONE, -Q_ONE, -Q_ONE, 40 * Q_ONE, Q_ONE,
                                  Q_ONE, 0, 0));
    directed.push_back(make_shape(CMD_BOX, 25 * Q_ONE - 1, -Q_ONE, -Q_ONE, 40 * Q_ONE, Q_ONE,
                                  Q_ONE, 0, 0));
    directed.push_back(make_shape(CMD_BOX, 10 * Q_ONE, 10 * Q_ONE, 10 * Q_ONE, -10 * Q_ONE,
                                  -10 * Q_ONE, -10 * Q_ONE, 0, 0));
    directed.push_back(make_shape(CMD_BOX, -Q_ONE, -Q_ONE, 75 * Q_ONE, Q_ONE, Q_ONE,
                                  200 * Q_ONE, 0, 0));
    directed.push_back(make_shape(CMD_BOX, -Q_ONE, -Q_ONE, 75 * Q_ONE - 1, Q_ONE, Q_ONE,
                                  200 * Q_ONE, 0, 0));
    // unused command never hits
    directed.push_back(make_shape(CMD_NONE, 0, 0, 0, 0, 0, 0, 25 * Q_ONE, 50 * Q_ONE));
    // field extremes on every command
    directed.push_back(make_shape(CMD_CAPSULE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  32'h7FFFFFFF, 32'h7FFFFFFF));
    directed.push_back(make_shape(CMD_SPHERE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  32'h7FFFFFFF, 32'h7FFFFFFF));
    directed.push_back(make_shape(CMD_BOX, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  32'h7FFFFFFF, 32'h7FFFFFFF));
    directed.push_back(make_shape(CMD_NONE, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                  32'h7FFFFFFF, 32'h7FFFFFFF));
    directed.push_back(make_shape(CMD_CAPSULE, 32'h80000000, 32'h80000000, 32'h80000000,
                                  32'h80000000, 32'h80000000, 32'h80000000, 0, 0));
    directed.push_back(make_shape(CMD_SPHERE, 32'h80000000, 32'h80000000, 32'h80000000,
                                  32'h80000000, 32'h80000000, 32'h80000000, 0, 0));
    directed.push_back(make_shape(CMD_BOX, 32'h80000000, 32'h80000000, 32'h80000000,
                                  32'h80000000, 32'h80000000, 32'h80000000, 0, 0));
    directed.push_back(make_shape(CMD_BOX, 32'h80000000, 32'h80000000, 32'h80000000,
                                  32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) send_shape(directed[i]);
    pause_sender(3);
    send_random(170);

    // Capsule settings: short-capsule edges, zero size, extremes, then random ones
    for (int p = 1; p <= 9; p++) begin
      cx = $urandom_range(0, 20 * Q_ONE) - 10 * Q_ONE;
      cy = $urandom_range(0, 20 * Q_ONE) - 10 * Q_ONE;
      cz = $urandom_range(0, 20 * Q_ONE) - 10 * Q_ONE;
      case (p)
        1: begin
          hh = SHORT_HALF_HEIGHT;
          rad = 10 * Q_ONE;
        end
        2: begin
          hh = SHORT_HALF_HEIGHT + 1;
          rad = 3 * Q_ONE;
        end
        3: begin
          cx = 0;
          cy = 0;
          cz = 0;
          hh = 0;
          rad = 0;
        end
        4: begin
          cx = 32'h80000000;
          cy = 32'h7FFFFFFF;
          cz = 32'h80000000;
          hh = 32'hFFFFFFFF;
          rad = 32'hFFFFFFFF;
        end
        5: begin
          cx = 32'h7FFFFFFF;
          cy = 32'h80000000;
          cz = 32'h7FFFFFFF;
          hh = 32'h7FFFFFFF;
          rad = 0;
        end
        default: begin
          cx = $urandom;
          cy = $urandom;
          cz = $urandom;
          hh = pick_length();
          rad = pick_length();
        end
      endcase
      drain_results();
      program_capsule(cx, cy, cz, hh, rad);
      send_random(190);
    end

    drain_results();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
